>>> sv/ale_pkg.sv
// package for the array list engine: sizes, opcodes, status codes
// no dependencies
package ale_pkg;
  localparam int Capacity = 64;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = AddrW + 1;

  localparam logic [3:0] OP_APPEND = 4'd0;
  localparam logic [3:0] OP_INSERT = 4'd1;
  localparam logic [3:0] OP_DELETE = 4'd2;
  localparam logic [3:0] OP_SEARCH = 4'd3;
  localparam logic [3:0] OP_SEARCH_MTF = 4'd4;
  localparam logic [3:0] OP_BSEARCH = 4'd5;
  localparam logic [3:0] OP_SET = 4'd6;
  localparam logic [3:0] OP_MAX = 4'd7;
  localparam logic [3:0] OP_SUM = 4'd8;
  localparam logic [3:0] OP_REVERSE = 4'd9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [3:0] opcode;
    logic [6:0] index;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] found_index;
    logic signed [31:0] result_value;
    logic [6:0] count;
  } rsp_t;
endpackage

>>> sv/ale_if.sv
// valid/ready channel interfaces for commands and results
// depends on ale_pkg
interface ale_cmd_if;
  logic valid;
  logic ready;
  ale_pkg::cmd_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ale_rsp_if;
  logic valid;
  logic ready;
  ale_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> sv/ale_ram.sv
// generic single-port ram with registered read
// no dependencies
module ale_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> sv/array_list_engine_unit.sv
// array list engine top level: sequencer around one entry ram
// depends on ale_pkg, ale_if, ale_ram
//
// channel  | dir | payload
// cmd      | in  | opcode, index, value
// rsp      | out | status, found_index, result_value, count
// cfg      | in  | size_limit (write enable + data)
//
// one word at a time: a refused word, or one with no walk, goes straight to done;
// append and set write once; scans read entries in turn, shifts read and rewrite
// each moved entry, binary search reads one entry per probe, move to front adds
// a swap with entry 0, reverse swaps pairs; the worst is reverse of 64 entries.
// reset clears the count and sets the limit to 64; ram contents are not cleared.
// a finished result waits in the output register; the next word is taken once
// the engine is idle; it holds in its done state while an older result waits.
module array_list_engine_unit (
  input  logic        clk,
  input  logic        rst,
  ale_cmd_if.sink     cmd,
  ale_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  import ale_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;  // issue read at the walk address
  localparam logic [2:0] S_USE  = 3'd2;  // read data available
  localparam logic [2:0] S_RD2  = 3'd3;  // read the far entry of a swap
  localparam logic [2:0] S_USE2 = 3'd4;  // far entry lands in the near slot
  localparam logic [2:0] S_WR   = 3'd5;  // write tmp at ptr2
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [6:0] size_limit;
  logic [CountW-1:0] live_count;
  cmd_t c;
  logic [CountW-1:0] ptr, ptr2;   // walk pointers
  logic [CountW-1:0] lo, hiex;    // binary search window, hiex exclusive
  logic [31:0] acc, tmp;
  logic [1:0] st;
  logic [AddrW-1:0] fidx;
  logic rsp_valid;
  rsp_t rsp_data;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;

  logic [CountW-1:0] lim, ptr_up, ptr_dn, ptr2_dn, mid, mid_up;
  logic [CountW:0] mid_sum;
  logic accept, rsp_load;
  logic [1:0] st_start;
  logic [2:0] nxt_start;
  logic [CountW-1:0] ptr_start, ptr2_start, count_start;

  ale_ram #(.Width(32), .Depth(Capacity)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign lim = (size_limit > 7'(Capacity)) ? CountW'(Capacity) : CountW'(size_limit);
  assign ptr_up = ptr + 1'b1;
  assign ptr_dn = ptr - 1'b1;
  assign ptr2_dn = ptr2 - 1'b1;
  assign mid_sum = {1'b0, lo} + {1'b0, hiex} - 1'b1;
  assign mid = mid_sum[CountW:1];
  assign mid_up = mid + 1'b1;

  assign cmd.ready = (state == S_IDLE);
  assign accept = cmd.valid && (state == S_IDLE);
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp.ready);
  assign rsp.valid = rsp_valid;
  assign rsp.data = rsp_data;

  // decode of an accepted word
  always_comb begin
    st_start = ST_OK;
    nxt_start = S_DONE;
    ptr_start = '0;
    ptr2_start = '0;
    count_start = live_count;
    unique case (cmd.data.opcode)
      OP_APPEND: begin
        if (live_count < lim) begin
          ptr2_start = live_count;
          nxt_start = S_WR;
          count_start = live_count + 1'b1;
        end else st_start = ST_REJECT;
      end
      OP_INSERT: begin
        if (live_count < lim && cmd.data.index <= 7'(live_count)) begin
          ptr_start = live_count;
          ptr2_start = CountW'(cmd.data.index);
          nxt_start = (cmd.data.index == 7'(live_count)) ? S_WR : S_READ;
          count_start = live_count + 1'b1;
        end else st_start = ST_REJECT;
      end
      OP_DELETE: begin
        if (cmd.data.index < 7'(live_count)) begin
          ptr_start = CountW'(cmd.data.index);
          ptr2_start = live_count - 1'b1;
          nxt_start = (cmd.data.index == 7'(live_count - 1'b1)) ? S_DONE : S_READ;
          count_start = live_count - 1'b1;
        end else st_start = ST_REJECT;
      end
      OP_SEARCH, OP_SEARCH_MTF, OP_BSEARCH, OP_MAX: begin
        if (live_count == '0) st_start = ST_MISS;
        else nxt_start = S_READ;
      end
      OP_SUM: begin
        if (live_count != '0) nxt_start = S_READ;
      end
      OP_SET: begin
        if (cmd.data.index < 7'(live_count)) begin
          ptr2_start = CountW'(cmd.data.index);
          nxt_start = S_WR;
        end else st_start = ST_REJECT;
      end
      OP_REVERSE: begin
        ptr2_start = live_count - 1'b1;
        if (live_count > CountW'(1)) nxt_start = S_READ;
      end
      default: st_start = ST_REJECT;
    endcase
  end

  // ram port control
  always_comb begin
    ram_we = 1'b0;
    ram_addr = ptr[AddrW-1:0];
    ram_wdata = ram_rdata;
    unique case (state)
      S_READ: begin
        unique case (c.opcode)
          OP_INSERT: ram_addr = ptr_dn[AddrW-1:0];
          OP_DELETE: ram_addr = ptr_up[AddrW-1:0];
          OP_BSEARCH: ram_addr = mid[AddrW-1:0];
          default: ram_addr = ptr[AddrW-1:0];
        endcase
      end
      // shifts write the entry just read into ptr
      S_USE: ram_we = (c.opcode == OP_INSERT) || (c.opcode == OP_DELETE);
      S_RD2: ram_addr = ptr2[AddrW-1:0];
      S_USE2: ram_we = 1'b1;
      S_WR: begin
        ram_we = 1'b1;
        ram_addr = ptr2[AddrW-1:0];
        ram_wdata = tmp;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size_limit <= 7'd64;
      live_count <= '0;
    end else begin
      if (cfg_we) size_limit <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            c <= cmd.data;
            st <= st_start;
            fidx <= '0;
            acc <= (cmd.data.opcode == OP_SET && nxt_start == S_WR) ? cmd.data.value : '0;
            tmp <= cmd.data.value;
            ptr <= ptr_start;
            ptr2 <= ptr2_start;
            lo <= '0;
            hiex <= live_count;
            live_count <= count_start;
            state <= nxt_start;
          end
        end
        S_READ: state <= S_USE;
        S_USE: begin
          unique case (c.opcode)
            OP_INSERT: begin
              ptr <= ptr_dn;
              state <= (ptr_dn == ptr2) ? S_WR : S_READ;
            end
            OP_DELETE: begin
              ptr <= ptr_up;
              state <= (ptr_up == ptr2) ? S_DONE : S_READ;
            end
            OP_SEARCH, OP_SEARCH_MTF: begin
              if (ram_rdata == c.value) begin
                fidx <= ptr[AddrW-1:0];
                // move to front swaps the hit with entry 0
                if (c.opcode == OP_SEARCH_MTF && ptr != '0) state <= S_RD2;
                else state <= S_DONE;
              end else if (ptr_up == live_count) begin
                st <= ST_MISS;
                state <= S_DONE;
              end else begin
                ptr <= ptr_up;
                state <= S_READ;
              end
            end
            OP_MAX, OP_SUM: begin
              if (c.opcode == OP_SUM) acc <= acc + ram_rdata;
              else if (ptr == '0 || $signed(ram_rdata) > $signed(acc)) acc <= ram_rdata;
              if (ptr_up == live_count) state <= S_DONE;
              else begin
                ptr <= ptr_up;
                state <= S_READ;
              end
            end
            OP_BSEARCH: begin
              if (ram_rdata == c.value) begin
                fidx <= mid[AddrW-1:0];
                state <= S_DONE;
              end else if ($signed(c.value) < $signed(ram_rdata)) begin
                hiex <= mid;
                if (lo < mid) state <= S_READ;
                else begin
                  st <= ST_MISS;
                  state <= S_DONE;
                end
              end else begin
                lo <= mid_up;
                if (mid_up < hiex) state <= S_READ;
                else begin
                  st <= ST_MISS;
                  state <= S_DONE;
                end
              end
            end
            OP_REVERSE: begin
              tmp <= ram_rdata;
              state <= S_RD2;
            end
            default: state <= S_DONE;
          endcase
        end
        S_RD2: state <= S_USE2;
        S_USE2: state <= S_WR;
        S_WR: begin
          // reverse goes on while the two pointers have not met
          if (c.opcode == OP_REVERSE && ptr_up < ptr2_dn) begin
            ptr <= ptr_up;
            ptr2 <= ptr2_dn;
            state <= S_READ;
          end else state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp_data.status <= st;
            rsp_data.found_index <= fidx;
            rsp_data.result_value <= (c.opcode == OP_MAX || c.opcode == OP_SUM
                                     || c.opcode == OP_SET) ? acc : '0;
            rsp_data.count <= 7'(live_count);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (rsp_load) rsp_valid <= 1'b1;
    else if (rsp.ready) rsp_valid <= 1'b0;
  end
endmodule
